// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock outside reset.
`define SSNR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked on every clock outside reset.
`define SSNR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ssnr_pkg.sv -----
// Types, constants and the digit decoder for the seven-segment rectangle generator.
package ssnr_pkg;

  // floor(x * 52429 / 2^19) == x / 10 and floor(x * 52429 / 2^18) == x / 5 for 16-bit x
  localparam int unsigned DivRecip   = 52429;
  localparam int unsigned Div10Shift = 19;
  localparam int unsigned Div5Shift  = 18;
  // floor(ht * 205 / 2^11) == ht / 10 for ht < 1029
  localparam int unsigned StrokeRecip = 205;
  localparam int unsigned StrokeShift = 11;
  localparam int unsigned DwNum       = 11;
  localparam int unsigned Ten         = 10;

  localparam logic [6:0] SegPatterns [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef enum logic [2:0] {
    SEG_A = 3'd0,
    SEG_B = 3'd1,
    SEG_C = 3'd2,
    SEG_D = 3'd3,
    SEG_E = 3'd4,
    SEG_F = 3'd5,
    SEG_G = 3'd6
  } seg_e;

  typedef struct packed {
    logic [15:0] number_value;
    logic [11:0] center_x;
    logic [11:0] top_y;
    logic [9:0]  digit_height;
    logic        ink_in;
    logic        outline_in;
  } in_word_t;

  typedef struct packed {
    logic signed [13:0] rect_x;
    logic [12:0]        rect_y;
    logic [9:0]         rect_w;
    logic [9:0]         rect_h;
    logic               ink_out;
    logic               outline_out;
    logic               last_rect;
  } out_word_t;

  // per-number geometry handed from the front pipeline to the emitter
  typedef struct packed {
    logic signed [13:0] x0;
    logic [11:0]        top_y;
    logic [9:0]         step;
    logic [6:0]         t;
    logic [9:0]         dw2t;
    logic [9:0]         dwt;
    logic [8:0]         halft;
    logic [9:0]         htt;
    logic [8:0]         hmid;
    logic [8:0]         half;
    logic [2:0][6:0]    masks;
    logic [1:0]         ndig_m1;
    logic               ink;
    logic               outl;
  } geom_t;

  typedef struct packed {
    logic       busy;
    logic [6:0] rem;
  } emit_st_t;

  function automatic logic [6:0] seg_decode(input logic [3:0] d);
    logic [6:0] r;
    r = 7'h00;
    if (d < 4'(Ten)) begin
      r = SegPatterns[d];
    end
    return r;
  endfunction

endpackage

// ----- rtl/ssnr_geom.sv -----
// Four-stage pipeline: decimal digits, segment masks and digit geometry per number.
module ssnr_geom (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ssnr_pkg::in_word_t in_word_i,
  output logic              geom_valid_o,
  input  logic              geom_take_i,
  output ssnr_pkg::geom_t   geom_o
);
  import ssnr_pkg::*;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic [31:0] p1_q10;
  logic [17:0] p1_t;
  logic [13:0] p1_a;
  logic [1:0]  p1_ndig;
  logic [15:0] s1_value_q;
  logic [12:0] s1_q10_q;
  logic [6:0]  s1_t_q;
  logic [11:0] s1_a4_q;
  logic [9:0]  s1_ht_q;
  logic [11:0] s1_cx_q, s1_ty_q;
  logic        s1_ink_q, s1_outl_q;
  logic [1:0]  s1_ndig_q;

  // stage 2
  logic [27:0] p2_dw;
  logic [28:0] p2_q100;
  logic [15:0] p2_d0;
  logic [3:0]  s2_d0_q;
  logic [12:0] s2_q10_q;
  logic [9:0]  s2_q100_q;
  logic [9:0]  s2_dw_q;
  logic [6:0]  s2_t_q;
  logic [9:0]  s2_ht_q;
  logic [11:0] s2_cx_q, s2_ty_q;
  logic        s2_ink_q, s2_outl_q;
  logic [1:0]  s2_ndig_q;

  // stage 3
  logic [25:0] p3_q1000;
  logic [12:0] p3_d1;
  logic [8:0]  p3_half;
  logic [11:0] p3_dw_mul;
  logic [7:0]  p3_t_mul;
  logic [3:0]  s3_d0_q, s3_d1_q;
  logic [9:0]  s3_q100_q;
  logic [6:0]  s3_q1000_q;
  logic [11:0] s3_total_q;
  logic [9:0]  s3_step_q, s3_dw2t_q, s3_dwt_q, s3_htt_q;
  logic [8:0]  s3_halft_q, s3_hmid_q, s3_half_q;
  logic [6:0]  s3_t_q;
  logic [11:0] s3_cx_q, s3_ty_q;
  logic        s3_ink_q, s3_outl_q;
  logic [1:0]  s3_ndig_q;

  // stage 4
  logic [9:0]  p4_d2;
  logic [6:0]  p4_pat0, p4_pat1, p4_pat2;
  geom_t       p4_geom, s4_q;

  assign en4 = !v4_q || geom_take_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign p1_q10 = {16'd0, in_word_i.number_value} * 32'(DivRecip);
  assign p1_t   = {8'd0, in_word_i.digit_height} * 18'(StrokeRecip);
  assign p1_a   = {4'd0, in_word_i.digit_height} * 14'(DwNum);
  assign p1_ndig = (in_word_i.number_value >= 16'd100) ? 2'd2 :
                   (in_word_i.number_value >= 16'd10)  ? 2'd1 : 2'd0;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_value_q <= in_word_i.number_value;
      s1_q10_q   <= p1_q10[Div10Shift +: 13];
      s1_t_q     <= p1_t[StrokeShift +: 7];
      s1_a4_q    <= p1_a[13:2];
      s1_ht_q    <= in_word_i.digit_height;
      s1_cx_q    <= in_word_i.center_x;
      s1_ty_q    <= in_word_i.top_y;
      s1_ink_q   <= in_word_i.ink_in;
      s1_outl_q  <= in_word_i.outline_in;
      s1_ndig_q  <= p1_ndig;
    end
  end

  assign p2_dw   = {16'd0, s1_a4_q} * 28'(DivRecip);
  assign p2_q100 = {16'd0, s1_q10_q} * 29'(DivRecip);
  assign p2_d0   = s1_value_q - 16'({3'd0, s1_q10_q} * 16'(Ten));

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_d0_q   <= p2_d0[3:0];
      s2_q10_q  <= s1_q10_q;
      s2_q100_q <= p2_q100[Div10Shift +: 10];
      s2_dw_q   <= p2_dw[Div5Shift +: 10];
      s2_t_q    <= s1_t_q;
      s2_ht_q   <= s1_ht_q;
      s2_cx_q   <= s1_cx_q;
      s2_ty_q   <= s1_ty_q;
      s2_ink_q  <= s1_ink_q;
      s2_outl_q <= s1_outl_q;
      s2_ndig_q <= s1_ndig_q;
    end
  end

  assign p3_q1000 = {16'd0, s2_q100_q} * 26'(DivRecip);
  assign p3_d1    = s2_q10_q - 13'({3'd0, s2_q100_q} * 13'(Ten));
  assign p3_half  = s2_ht_q[9:1];

  always_comb begin
    case (s2_ndig_q)
      2'd0: begin
        p3_dw_mul = {2'b0, s2_dw_q};
        p3_t_mul  = 8'd0;
      end
      2'd1: begin
        p3_dw_mul = {1'b0, s2_dw_q, 1'b0};
        p3_t_mul  = {1'b0, s2_t_q};
      end
      2'd2: begin
        p3_dw_mul = {2'b0, s2_dw_q} + {1'b0, s2_dw_q, 1'b0};
        p3_t_mul  = {s2_t_q, 1'b0};
      end
      default: begin
        p3_dw_mul = 12'd0;
        p3_t_mul  = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_d0_q    <= s2_d0_q;
      s3_d1_q    <= p3_d1[3:0];
      s3_q100_q  <= s2_q100_q;
      s3_q1000_q <= p3_q1000[Div10Shift +: 7];
      s3_total_q <= p3_dw_mul + {4'd0, p3_t_mul};
      s3_step_q  <= s2_dw_q + {3'd0, s2_t_q};
      s3_dw2t_q  <= s2_dw_q - {2'd0, s2_t_q, 1'b0};
      s3_dwt_q   <= s2_dw_q - {3'd0, s2_t_q};
      s3_htt_q   <= s2_ht_q - {3'd0, s2_t_q};
      s3_halft_q <= p3_half - {2'd0, s2_t_q};
      s3_hmid_q  <= p3_half - {3'd0, s2_t_q[6:1]};
      s3_half_q  <= p3_half;
      s3_t_q     <= s2_t_q;
      s3_cx_q    <= s2_cx_q;
      s3_ty_q    <= s2_ty_q;
      s3_ink_q   <= s2_ink_q;
      s3_outl_q  <= s2_outl_q;
      s3_ndig_q  <= s2_ndig_q;
    end
  end

  assign p4_d2   = s3_q100_q - 10'({3'd0, s3_q1000_q} * 10'(Ten));
  assign p4_pat0 = seg_decode(s3_d0_q);
  assign p4_pat1 = seg_decode(s3_d1_q);
  assign p4_pat2 = seg_decode(p4_d2[3:0]);

  always_comb begin
    p4_geom.x0      = $signed({2'd0, s3_cx_q}) - $signed({3'd0, s3_total_q[11:1]});
    p4_geom.top_y   = s3_ty_q;
    p4_geom.step    = s3_step_q;
    p4_geom.t       = s3_t_q;
    p4_geom.dw2t    = s3_dw2t_q;
    p4_geom.dwt     = s3_dwt_q;
    p4_geom.halft   = s3_halft_q;
    p4_geom.htt     = s3_htt_q;
    p4_geom.hmid    = s3_hmid_q;
    p4_geom.half    = s3_half_q;
    p4_geom.ndig_m1 = s3_ndig_q;
    p4_geom.ink     = s3_ink_q;
    p4_geom.outl    = s3_outl_q;
    // left digit first
    case (s3_ndig_q)
      2'd0:    p4_geom.masks = {7'h00, 7'h00, p4_pat0};
      2'd1:    p4_geom.masks = {7'h00, p4_pat0, p4_pat1};
      2'd2:    p4_geom.masks = {p4_pat0, p4_pat1, p4_pat2};
      default: p4_geom.masks = {7'h00, 7'h00, p4_pat0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) s4_q <= p4_geom;
  end

  assign geom_valid_o = v4_q;
  assign geom_o       = s4_q;

endmodule

// ----- rtl/ssnr_emit.sv -----
// Segment walker: one rectangle word per cycle while out_stall_i is low, into a registered output.
module ssnr_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               geom_valid_i,
  output logic               geom_take_o,
  input  ssnr_pkg::geom_t    geom_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssnr_pkg::out_word_t out_word_o,
  output ssnr_pkg::emit_st_t st_o
);
  import ssnr_pkg::*;

  geom_t       g_q;
  logic        busy_q;
  logic [1:0]  dig_q;
  logic [1:0]  dig_nxt;
  logic [6:0]  rem_q, rem_nxt;
  logic signed [13:0] cur_x_q;
  logic        out_valid_q;
  out_word_t   out_q, rect;

  logic   out_load, emit, seg_done, last_dig, item_done, take;
  seg_e   sel;
  logic [9:0] xoff, yoff;

  assign out_load  = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && out_load;
  assign rem_nxt   = rem_q & (rem_q - 7'd1);
  assign seg_done  = (rem_nxt == 7'd0);
  assign last_dig  = (dig_q == g_q.ndig_m1);
  assign item_done = seg_done && last_dig;
  assign take      = geom_valid_i && (!busy_q || (emit && item_done));
  assign dig_nxt   = dig_q + 2'd1;

  always_comb begin
    sel = SEG_A;
    for (int i = 6; i >= 0; i--) begin
      if (rem_q[i]) sel = seg_e'(3'(i));
    end
  end

  always_comb begin
    rect.ink_out     = g_q.ink;
    rect.outline_out = g_q.outl;
    rect.last_rect   = item_done;
    case (sel)
      SEG_A: begin
        xoff = {3'd0, g_q.t}; yoff = 10'd0;
        rect.rect_w = g_q.dw2t; rect.rect_h = {3'd0, g_q.t};
      end
      SEG_B: begin
        xoff = g_q.dwt; yoff = {3'd0, g_q.t};
        rect.rect_w = {3'd0, g_q.t}; rect.rect_h = {1'b0, g_q.halft};
      end
      SEG_C: begin
        xoff = g_q.dwt; yoff = {1'b0, g_q.half};
        rect.rect_w = {3'd0, g_q.t}; rect.rect_h = {1'b0, g_q.halft};
      end
      SEG_D: begin
        xoff = {3'd0, g_q.t}; yoff = g_q.htt;
        rect.rect_w = g_q.dw2t; rect.rect_h = {3'd0, g_q.t};
      end
      SEG_E: begin
        xoff = 10'd0; yoff = {1'b0, g_q.half};
        rect.rect_w = {3'd0, g_q.t}; rect.rect_h = {1'b0, g_q.halft};
      end
      SEG_F: begin
        xoff = 10'd0; yoff = {3'd0, g_q.t};
        rect.rect_w = {3'd0, g_q.t}; rect.rect_h = {1'b0, g_q.halft};
      end
      SEG_G: begin
        xoff = {3'd0, g_q.t}; yoff = {1'b0, g_q.hmid};
        rect.rect_w = g_q.dw2t; rect.rect_h = {3'd0, g_q.t};
      end
      default: begin
        xoff = 10'd0; yoff = 10'd0;
        rect.rect_w = 10'd0; rect.rect_h = 10'd0;
      end
    endcase
    rect.rect_x = cur_x_q + $signed({4'd0, xoff});
    rect.rect_y = {1'b0, g_q.top_y} + {3'd0, yoff};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      dig_q       <= 2'd0;
      rem_q       <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= emit;
      if (take) begin
        busy_q <= 1'b1;
        dig_q  <= 2'd0;
        rem_q  <= geom_i.masks[0];
      end else if (emit) begin
        if (item_done) begin
          busy_q <= 1'b0;
          rem_q  <= 7'd0;
        end else if (seg_done) begin
          dig_q <= dig_nxt;
          rem_q <= g_q.masks[dig_nxt];
        end else begin
          rem_q <= rem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      g_q     <= geom_i;
      cur_x_q <= geom_i.x0;
    end else if (emit && seg_done) begin
      cur_x_q <= cur_x_q + $signed({4'd0, g_q.step});
    end
    if (emit) out_q <= rect;
  end

  assign geom_take_o = take;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign st_o.busy   = busy_q;
  assign st_o.rem    = rem_q;

endmodule

// ----- rtl/seven_segment_number_rects.sv -----
// Top level: number to seven-segment rectangle words.
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_stall_o   in_word_t: number, position, height, flags
//   out      output     out_valid_o / out_stall_i out_word_t: one rectangle per lit segment
//
// An accepted number passes the four front stages and the walker's geometry register
// before its first word reaches the output register. One rectangle word per cycle while
// out_stall_i is low; a number gives 2 to 21 words, one per lit segment, from the single
// segment walker that feeds the output register. The next number's geometry is computed
// in the four-stage front pipeline meanwhile, so words of consecutive numbers follow
// without a gap. Reset clears all valid bits; a stall holds only the valid stages.
`include "assert_macros.svh"

module seven_segment_number_rects (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssnr_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssnr_pkg::out_word_t out_word_o
);
  import ssnr_pkg::*;

  logic     geom_valid, geom_take;
  geom_t    geom;
  emit_st_t st;

  ssnr_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .geom_valid_o(geom_valid),
    .geom_take_i (geom_take),
    .geom_o      (geom)
  );

  ssnr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_valid_i(geom_valid),
    .geom_take_o (geom_take),
    .geom_i      (geom),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .st_o        (st)
  );

  `SSNR_ASSERT_IMPL(a_out_from_busy, $rose(out_valid_o), $past(st.busy), "word without walker")
  `SSNR_ASSERT_IMPL(a_busy_has_seg, st.busy, st.rem != 7'd0, "walker busy with empty mask")
  `SSNR_ASSERT(a_take_needs_valid, !geom_take || geom_valid, "geometry taken while empty")

endmodule
